// ===== src/scvp_pkg.sv =====
// ============================================================================
// S-curve profile package
// Shared widths, saturation helpers, configuration codes and sequencer states.
// ============================================================================
package scvp_pkg;

    localparam int CFG_W     = 32;           // configuration register width
    localparam int T_W       = 32;           // time input width
    localparam int OUT_W     = 32;           // result field width
    localparam int Q_W       = 47;           // internal magnitude, clamped to 2^46
    localparam int DIV_W     = 48;           // serial divider dividend and quotient
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_JERK     = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 32'h0001_0000;

    typedef logic [Q_W-1:0] t_q;

    localparam t_q QCAP = 47'h4000_0000_0000;

    typedef enum logic [3:0] {
        CS_DIV_T1,
        CS_DIV_T2,
        CS_DIV_TC,
        CS_SUMS,
        CS_MUL_JT1,
        CS_MUL_Q2,
        CS_MUL_Q3,
        CS_MUL_VT3,
        CS_MUL_Q3D6,
        CS_IDLE
    } t_cfg_state;

    // Limit-derived constants: the user must hold them stable for items in flight.
    typedef struct packed {
        logic [CFG_W-1:0] v;
        logic [CFG_W-1:0] a;
        logic [CFG_W-1:0] j;
        t_q               t1;
        t_q               t2;
        t_q               t3;
        t_q               tt;
        t_q               t4;
        t_q               q2;
        t_q               q2h;
        t_q               q3d6;
        t_q               vt3h;
    } t_prof_consts;

    // Takes a full product, drops the 16 fraction bits and clamps to 2^46.
    function automatic t_q qclamp_prod(input logic [2*Q_W-1:0] p);
        logic [2*Q_W-17:0] sh;
        sh = p[2*Q_W-1:16];
        return (sh > (2*Q_W-16)'(QCAP)) ? QCAP : sh[Q_W-1:0];
    endfunction

    // Unsigned sum clamped to 2^46.
    function automatic t_q qsat_add(input t_q x, input t_q y);
        logic [Q_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s > {1'b0, QCAP}) ? QCAP : s[Q_W-1:0];
    endfunction

endpackage

// ===== src/scvp_in_if.sv =====
// ============================================================================
// S-curve input channel
// Carries one time point per transfer with a valid and ready handshake.
// ============================================================================
interface scvp_in_if import scvp_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [T_W-1:0] time_point;

    modport source (output valid, output time_point, input ready);
    modport sink   (input valid, input time_point, output ready);
endinterface

// ===== src/scvp_out_if.sv =====
// ============================================================================
// S-curve output channel
// Carries position, velocity and the in-profile flag per transfer.
// ============================================================================
interface scvp_out_if import scvp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] path_position;
    logic signed [OUT_W-1:0] path_velocity;
    logic                    in_profile;

    modport source (output valid, output path_position, output path_velocity,
                    output in_profile, input ready);
    modport sink   (input valid, input path_position, input path_velocity,
                    input in_profile, output ready);
endinterface

// ===== src/scvp_qmul.sv =====
// ============================================================================
// S-curve fixed-point multiplier
// Registers four partial products, then sums, scales and clamps them.
// ============================================================================
module scvp_qmul import scvp_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_q   i_a,
    input  t_q   i_b,
    output t_q   o_prod
);
    localparam int LO_W = 24;
    localparam int HI_W = Q_W - LO_W;

    logic [2*LO_W-1:0]      r_ll;
    logic [LO_W+HI_W-1:0]   r_lh;
    logic [LO_W+HI_W-1:0]   r_hl;
    logic [2*HI_W-1:0]      r_hh;
    logic [2*Q_W-1:0]       sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[LO_W-1:0]   * i_b[LO_W-1:0];
            r_lh <= i_a[LO_W-1:0]   * i_b[Q_W-1:LO_W];
            r_hl <= i_a[Q_W-1:LO_W] * i_b[LO_W-1:0];
            r_hh <= i_a[Q_W-1:LO_W] * i_b[Q_W-1:LO_W];
        end
    end

    always_comb begin
        sum = (2*Q_W)'(r_ll)
            + ((2*Q_W)'(r_lh) << LO_W)
            + ((2*Q_W)'(r_hl) << LO_W)
            + ((2*Q_W)'(r_hh) << (2*LO_W));
        o_prod = qclamp_prod(sum);
    end
endmodule

// ===== src/scvp_cfg.sv =====
// ============================================================================
// S-curve configuration unit
// Holds the limits and derives the segment times and profile constants.
// ============================================================================
module scvp_cfg import scvp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_busy,
    output t_prof_consts         o_consts
);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(Q_W - 1);
    // q3 / 6 is formed as ((q3 / 2) * ceil(2^48 / 3)) >> 48, exact below 2^47.
    localparam t_q               REC3     = 47'd93824992236886;
    localparam int               REC3_SH  = 48;

    t_cfg_state        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CFG_W-1:0]  r_max_vel, r_max_acc, r_max_jerk;
    t_q                r_t1, r_t2, r_tc, r_t3, r_tt, r_t4;
    t_q                r_jt1, r_q2, r_q3, r_vt3h, r_q3d6;
    logic [CFG_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [2*Q_W-1:0]  r_macc, n_macc;

    logic              is_div, is_mul, step_last;
    logic [DIV_W-1:0]  dividend;
    logic [CFG_W-1:0]  divisor;
    t_q                mul_a, mul_b;
    t_q                div_res, mul_res, t3_sum, tt_sum;

    logic [CFG_W-1:0]  cur_rem;
    logic [DIV_W-1:0]  cur_quo;
    logic [CFG_W:0]    rem_sh;
    logic              rem_ge;
    logic [2*Q_W-1:0]  cur_macc;
    logic [Q_W:0]      macc_top;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            CS_DIV_T1:   if (r_cnt == DIV_LAST) n_state = CS_DIV_T2;
            CS_DIV_T2:   if (r_cnt == DIV_LAST) n_state = CS_DIV_TC;
            CS_DIV_TC:   if (r_cnt == DIV_LAST) n_state = CS_SUMS;
            CS_SUMS:     n_state = CS_MUL_JT1;
            CS_MUL_JT1:  if (r_cnt == MUL_LAST) n_state = CS_MUL_Q2;
            CS_MUL_Q2:   if (r_cnt == MUL_LAST) n_state = CS_MUL_Q3;
            CS_MUL_Q3:   if (r_cnt == MUL_LAST) n_state = CS_MUL_VT3;
            CS_MUL_VT3:  if (r_cnt == MUL_LAST) n_state = CS_MUL_Q3D6;
            CS_MUL_Q3D6: if (r_cnt == MUL_LAST) n_state = CS_IDLE;
            CS_IDLE:     n_state = CS_IDLE;
            default:     n_state = CS_IDLE;
        endcase
        if (i_cfg_we) begin
            n_state = CS_DIV_T1;
        end
    end

    // Outputs and operand selection.
    always_comb begin
        o_busy   = (r_state != CS_IDLE);
        is_div   = 1'b0;
        is_mul   = 1'b0;
        dividend = '0;
        divisor  = '0;
        mul_a    = '0;
        mul_b    = '0;
        case (r_state)
            CS_DIV_T1: begin
                is_div   = 1'b1;
                dividend = {r_max_acc, 16'h0000};
                divisor  = r_max_jerk;
            end
            CS_DIV_T2: begin
                is_div   = 1'b1;
                dividend = {r_max_vel, 16'h0000};
                divisor  = r_max_acc;
            end
            CS_DIV_TC: begin
                is_div   = 1'b1;
                dividend = 48'h0001_0000_0000;
                divisor  = r_max_vel;
            end
            CS_MUL_JT1: begin
                is_mul = 1'b1;
                mul_a  = Q_W'(r_max_jerk);
                mul_b  = r_t1;
            end
            CS_MUL_Q2: begin
                is_mul = 1'b1;
                mul_a  = r_jt1;
                mul_b  = r_t1;
            end
            CS_MUL_Q3: begin
                is_mul = 1'b1;
                mul_a  = r_q2;
                mul_b  = r_t1;
            end
            CS_MUL_VT3: begin
                is_mul = 1'b1;
                mul_a  = Q_W'(r_max_vel);
                mul_b  = r_t3;
            end
            CS_MUL_Q3D6: begin
                is_mul = 1'b1;
                mul_a  = REC3;
                mul_b  = r_q3 >> 1;
            end
            default: begin
            end
        endcase
        step_last = (is_div && (r_cnt == DIV_LAST)) || (is_mul && (r_cnt == MUL_LAST));

        o_consts.v    = r_max_vel;
        o_consts.a    = r_max_acc;
        o_consts.j    = r_max_jerk;
        o_consts.t1   = r_t1;
        o_consts.t2   = r_t2;
        o_consts.t3   = r_t3;
        o_consts.tt   = r_tt;
        o_consts.t4   = r_t4;
        o_consts.q2   = r_q2;
        o_consts.q2h  = r_q2 >> 1;
        o_consts.q3d6 = r_q3d6;
        o_consts.vt3h = r_vt3h;
    end

    // One restoring division bit and one shift-add multiply bit per cycle.
    always_comb begin
        cur_rem  = (r_cnt == '0) ? '0 : r_rem;
        cur_quo  = (r_cnt == '0) ? dividend : r_quo;
        rem_sh   = {cur_rem, cur_quo[DIV_W-1]};
        rem_ge   = (rem_sh >= {1'b0, divisor});
        n_rem    = rem_ge ? CFG_W'(rem_sh - {1'b0, divisor}) : rem_sh[CFG_W-1:0];
        n_quo    = {cur_quo[DIV_W-2:0], rem_ge};
        div_res  = (n_quo > DIV_W'(QCAP)) ? QCAP : n_quo[Q_W-1:0];

        cur_macc = (r_cnt == '0) ? {{Q_W{1'b0}}, mul_b} : r_macc;
        macc_top = {1'b0, cur_macc[2*Q_W-1:Q_W]} + (cur_macc[0] ? {1'b0, mul_a} : '0);
        n_macc   = {macc_top, cur_macc[Q_W-1:1]};
        mul_res  = qclamp_prod(n_macc);

        t3_sum   = qsat_add(r_t1, r_t2);
        tt_sum   = qsat_add(t3_sum, r_tc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= CS_DIV_T1;
            r_cnt      <= '0;
            r_max_vel  <= CFG_RESET;
            r_max_acc  <= CFG_RESET;
            r_max_jerk <= CFG_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we || step_last || !(is_div || is_mul)) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_VELOCITY: r_max_vel  <= i_cfg_data;
                    CFG_MAX_ACCEL:    r_max_acc  <= i_cfg_data;
                    CFG_MAX_JERK:     r_max_jerk <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_macc <= n_macc;
        if (step_last) begin
            case (r_state)
                CS_DIV_T1:   r_t1   <= div_res;
                CS_DIV_T2:   r_t2   <= div_res;
                CS_DIV_TC:   r_tc   <= div_res;
                CS_MUL_JT1:  r_jt1  <= mul_res;
                CS_MUL_Q2:   r_q2   <= mul_res;
                CS_MUL_Q3:   r_q3   <= mul_res;
                CS_MUL_VT3:  r_vt3h <= mul_res >> 1;
                CS_MUL_Q3D6: r_q3d6 <= Q_W'(n_macc[2*Q_W-1:REC3_SH]);
                default: begin
                end
            endcase
        end
        if (r_state == CS_SUMS) begin
            r_t3 <= t3_sum;
            r_tt <= tt_sum;
            r_t4 <= tt_sum - t3_sum;
        end
    end
endmodule

// ===== src/s_curve_velocity_profile.sv =====
// ============================================================================
// S-curve velocity profile
// Twelve-stage pipeline that evaluates a jerk-limited seven-segment S-curve.
// ============================================================================
// Throughput: one time point per cycle while the configuration unit is idle
// and the output is not stalled, set by the fully pipelined multipliers.
// Reset (synchronous, active low) loads all limits with 1.0 and clears the
// pipeline valid bits. After reset and after every configuration write the
// block derives the segment times in a serial divider and multiplier;
// input ready stays low during that pass.
module s_curve_velocity_profile import scvp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    scvp_in_if.sink              i_in,
    scvp_out_if.source           o_out
);
    localparam int NST = 12;
    localparam int SW  = Q_W + 3;

    typedef logic signed [SW-1:0] t_sq;

    localparam t_sq SCAP    = t_sq'(QCAP);
    localparam t_sq SONE    = t_sq'(64'sd65536);
    localparam t_sq S32_MAX = t_sq'(64'sd2147483647);
    localparam t_sq S32_MIN = t_sq'(-64'sd2147483648);

    // Division by three is split as y = yh * 2^24 + yl.
    localparam logic [22:0] DIV3_HI  = 23'd5592405;   // (2^24 - 1) / 3
    localparam logic [23:0] DIV3_REC = 24'd11184811;  // ceil(2^25 / 3)

    typedef enum logic [1:0] {RG_OUT, RG_ACC, RG_CRUISE, RG_DEC} t_region;
    typedef enum logic [1:0] {
        SEG_JERK_UP, SEG_CONST_ACC, SEG_JERK_DOWN, SEG_CRUISE
    } t_seg;

    typedef struct packed {
        t_region          region;
        t_seg             seg;
        t_q               u;
        t_q               x;
        t_q               k1;
        t_q               k2;
        t_q               m1;
        t_q               p;
        t_q               m2;
        t_q               m3;
        logic [44:0]      pa;
        logic [23:0]      pb;
        t_q               m3d6;
        t_sq              s;
        t_sq              sd;
        logic [OUT_W-1:0] pos;
        logic [OUT_W-1:0] vel;
        logic             inp;
    } t_stage;

    function automatic t_sq sclamp(input t_sq x);
        if (x > SCAP) return SCAP;
        if (x < -SCAP) return -SCAP;
        return x;
    endfunction

    function automatic logic [OUT_W-1:0] sat32(input t_sq x);
        if (x > S32_MAX) return S32_MAX[OUT_W-1:0];
        if (x < S32_MIN) return S32_MIN[OUT_W-1:0];
        return x[OUT_W-1:0];
    endfunction

    t_prof_consts      c;
    logic              cfg_busy;
    logic [NST-1:0]    r_v;
    logic [NST-1:0]    stage_en;
    t_stage            r_st [NST];
    t_stage            n_st [NST];
    logic              in_xfer;
    t_q                tq;
    t_q                qm1_out, qp_out, qm2_out, qm3_out;
    logic [45:0]       y;
    logic [24:0]       z;
    logic [48:0]       zr;
    t_sq               s_fin;

    scvp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_busy     (cfg_busy),
        .o_consts   (c)
    );

    // A stage advances when it is empty or the stage after it advances, so
    // bubbles collapse and a stalled output still lets earlier stages fill.
    always_comb begin
        stage_en[NST-1] = !r_v[NST-1] || o_out.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
    end

    assign i_in.ready = stage_en[0] && !cfg_busy;
    assign in_xfer    = i_in.valid && i_in.ready;

    // Four multipliers: the first pair forms M1 = k1 * x and P = k2 * x,
    // the next ones extend the polynomial by one more factor of x each.
    scvp_qmul u_qm1 (.i_clk(i_clk), .i_en(stage_en[2]),
                     .i_a(r_st[1].k1), .i_b(r_st[1].x), .o_prod(qm1_out));
    scvp_qmul u_qp  (.i_clk(i_clk), .i_en(stage_en[2]),
                     .i_a(r_st[1].k2), .i_b(r_st[1].x), .o_prod(qp_out));
    scvp_qmul u_qm2 (.i_clk(i_clk), .i_en(stage_en[4]),
                     .i_a(r_st[3].m1), .i_b(r_st[3].x), .o_prod(qm2_out));
    scvp_qmul u_qm3 (.i_clk(i_clk), .i_en(stage_en[6]),
                     .i_a(r_st[5].m2), .i_b(r_st[5].x), .o_prod(qm3_out));

    always_comb begin
        for (int k = 1; k < NST; k++) begin
            n_st[k] = r_st[k-1];
        end

        // Stage 0: place the time in the profile. In deceleration the
        // acceleration phase is evaluated at the mirrored time T - t.
        tq      = Q_W'(i_in.time_point);
        n_st[0] = '0;
        if (tq > c.tt) begin
            n_st[0].region = RG_OUT;
        end else if (tq <= c.t3) begin
            n_st[0].region = RG_ACC;
            n_st[0].u      = tq;
        end else if (tq <= c.t4) begin
            n_st[0].region = RG_CRUISE;
            n_st[0].u      = tq - c.t3;
        end else begin
            n_st[0].region = RG_DEC;
            n_st[0].u      = c.tt - tq;
        end

        // Stage 1: pick the segment, its local variable and coefficients.
        n_st[1].seg = SEG_CRUISE;
        n_st[1].x   = r_st[0].u;
        n_st[1].k1  = Q_W'(c.v);
        n_st[1].k2  = Q_W'(c.v);
        if (r_st[0].region == RG_ACC || r_st[0].region == RG_DEC) begin
            if (r_st[0].u <= c.t1) begin
                n_st[1].seg = SEG_JERK_UP;
                n_st[1].k1  = Q_W'(c.j);
            end else if (r_st[0].u <= c.t2) begin
                n_st[1].seg = SEG_CONST_ACC;
                n_st[1].x   = r_st[0].u - c.t1;
                n_st[1].k1  = Q_W'(c.a);
                n_st[1].k2  = c.q2;
            end else begin
                n_st[1].seg = SEG_JERK_DOWN;
                n_st[1].x   = (r_st[0].u <= c.t3) ? c.t3 - r_st[0].u : '0;
                n_st[1].k1  = Q_W'(c.j);
            end
        end

        n_st[3].m1 = qm1_out;
        n_st[3].p  = qp_out;
        n_st[5].m2 = qm2_out;
        n_st[7].m3 = qm3_out;

        // Stages 8 and 9: M3 / 6 as (M3 / 2) / 3 through a reciprocal.
        y          = r_st[7].m3[Q_W-1:1];
        z          = 25'(y[45:24]) + 25'(y[23:0]);
        zr         = z * DIV3_REC;
        n_st[8].pa = y[45:24] * DIV3_HI;
        n_st[8].pb = zr[48:25];
        n_st[9].m3d6 = Q_W'(r_st[8].pa) + Q_W'(r_st[8].pb);

        // Stage 10: position and velocity of the acceleration phase or cruise.
        case (r_st[9].seg)
            SEG_JERK_UP: begin
                n_st[10].sd = t_sq'(r_st[9].m2 >> 1);
                n_st[10].s  = t_sq'(r_st[9].m3d6);
            end
            SEG_CONST_ACC: begin
                n_st[10].sd = t_sq'(qsat_add(c.q2h, r_st[9].m1));
                n_st[10].s  = t_sq'(qsat_add(qsat_add(c.q3d6, r_st[9].p >> 1),
                                             r_st[9].m2 >> 1));
            end
            SEG_JERK_DOWN: begin
                n_st[10].sd = sclamp(t_sq'(c.v) - t_sq'(r_st[9].m2 >> 1));
                n_st[10].s  = sclamp(t_sq'(c.vt3h) - t_sq'(r_st[9].p)
                                     + t_sq'(r_st[9].m3d6));
            end
            SEG_CRUISE: begin
                n_st[10].sd = t_sq'(c.v);
                n_st[10].s  = t_sq'(qsat_add(c.vt3h, r_st[9].m1));
            end
            default: begin
                n_st[10].sd = '0;
                n_st[10].s  = '0;
            end
        endcase

        // Stage 11: mirror for deceleration, saturate, blank outside [0, T].
        s_fin = (r_st[10].region == RG_DEC) ? sclamp(SONE - r_st[10].s) : r_st[10].s;
        if (r_st[10].region == RG_OUT) begin
            n_st[11].pos = '0;
            n_st[11].vel = '0;
            n_st[11].inp = 1'b0;
        end else begin
            n_st[11].pos = sat32(s_fin);
            n_st[11].vel = sat32(r_st[10].sd);
            n_st[11].inp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_en[0]) begin
                r_v[0] <= in_xfer;
            end
            for (int k = 1; k < NST; k++) begin
                if (stage_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (stage_en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_out.valid         = r_v[NST-1];
    assign o_out.path_position = $signed(r_st[NST-1].pos);
    assign o_out.path_velocity = $signed(r_st[NST-1].vel);
    assign o_out.in_profile    = r_st[NST-1].inp;
endmodule
